// ===== hdl/ohst_pkg.sv =====
// shared types and constants for the ordered handle slot table
`default_nettype none

package ohst_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // link words hold a free-list pointer or a position, end of list is all ones
  localparam int         LINK_W   = 8;
  localparam logic [7:0] END_MARK = 8'hFF;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SET_FULL,
    OP_SET_RANGE,
    OP_ALLOC_RD,
    OP_ALLOC_WR,
    OP_LINK_RD,
    OP_OWNER_RD,
    OP_SET_WR,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_FREE_FIN,
    OP_READ_RD,
    OP_READ_WR,
    OP_EMIT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    req_t req;
    logic full;
    logic h_ok;
    logic pos_ok;
    logic live;
    logic shift_done;
    logic out_free;
  } dp_stat_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_WR,
    S_OWNER_RD,
    S_CHECK,
    S_SHIFT,
    S_FREE_FIN,
    S_READ_WR,
    S_EMIT
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== hdl/ohst_datapath.sv =====
// datapath: entry, link and owner memories, counters and result registers
`default_nettype none

module ohst_datapath
  import ohst_pkg::*;
#(
  parameter int MAX_ENTRIES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_op_t      op,
  output dp_stat_t         stat,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  handle,
  input  wire logic [6:0]  position,
  input  wire logic [15:0] attr_zero,
  input  wire logic [15:0] attr_one,
  input  wire logic [15:0] attr_two,
  input  wire logic [15:0] priority_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [6:0]       handle_out,
  output logic [15:0]      entry_attr_zero,
  output logic [15:0]      entry_attr_one,
  output logic [15:0]      entry_attr_two,
  output logic [15:0]      entry_priority,
  output logic [7:0]       live_count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [8:0] MAX9 = 9'(MAX_ENTRIES);
  localparam logic [AW:0] MAXA = (AW + 1)'(MAX_ENTRIES);

  // memories
  logic [63:0]       entry_mem [MAX_ENTRIES];
  logic [LINK_W-1:0] link_mem  [MAX_ENTRIES];
  logic [AW-1:0]     owner_mem [MAX_ENTRIES];

  // control registers
  logic [LINK_W-1:0] free_head;
  logic [CW-1:0]     count;
  logic [CW-1:0]     hw;
  logic              mv_valid;

  // payload registers
  req_t              req_q;
  logic [6:0]        h_q;
  logic [6:0]        pos_q;
  logic [63:0]       attr_q;
  logic [LINK_W-1:0] p_q;
  logic [CW-1:0]     rd_ptr;
  logic [AW-1:0]     mv_pos;
  logic [1:0]        wk_status;
  logic [6:0]        wk_handle;
  logic [63:0]       wk_entry;

  // registered read data
  logic [LINK_W-1:0] link_q;
  logic              link_fresh;
  logic [LINK_W-1:0] link_rstv;
  logic [AW-1:0]     owner_q;
  logic [63:0]       entry_q;

  logic [LINK_W-1:0] link_val;
  logic [AW-1:0]     link_raddr;
  logic              link_ren;
  logic [AW:0]       link_succ;
  logic [AW-1:0]     owner_raddr;
  logic              owner_ren;
  logic [AW-1:0]     entry_raddr;
  logic              entry_ren;
  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              owner_we;
  logic [AW-1:0]     owner_waddr;
  logic [AW-1:0]     owner_wdata;
  logic              entry_we;
  logic [AW-1:0]     entry_waddr;
  logic [63:0]       entry_wdata;
  logic [AW-1:0]     mv_dst;
  logic              shift_rd;

  // handles at or above the high-water mark were never written: they still
  // hold their reset chain value
  assign link_val  = link_fresh ? link_rstv : link_q;
  assign link_succ = {1'b0, link_raddr} + (AW + 1)'(1);
  assign mv_dst    = mv_pos - AW'(1);
  assign shift_rd  = (op == OP_SHIFT) && (rd_ptr < count);

  // read port selection
  always_comb begin
    link_ren    = (op == OP_ALLOC_RD) || (op == OP_LINK_RD);
    link_raddr  = (op == OP_ALLOC_RD) ? AW'(free_head) : AW'(h_q);
    owner_ren   = 1'b0;
    owner_raddr = AW'(pos_q);
    entry_ren   = 1'b0;
    entry_raddr = AW'(pos_q);
    case (op)
      OP_OWNER_RD: begin
        owner_ren   = 1'b1;
        owner_raddr = AW'(link_val);
      end
      OP_SHIFT: begin
        owner_ren   = shift_rd;
        owner_raddr = AW'(rd_ptr);
        entry_ren   = shift_rd;
        entry_raddr = AW'(rd_ptr);
      end
      OP_READ_RD: begin
        owner_ren = 1'b1;
        entry_ren = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // write port selection
  always_comb begin
    link_we     = 1'b0;
    link_waddr  = AW'(h_q);
    link_wdata  = free_head;
    owner_we    = 1'b0;
    owner_waddr = mv_dst;
    owner_wdata = owner_q;
    entry_we    = 1'b0;
    entry_waddr = mv_dst;
    entry_wdata = entry_q;
    case (op)
      OP_ALLOC_WR: begin
        link_we     = 1'b1;
        link_waddr  = AW'(free_head);
        link_wdata  = LINK_W'(count);
        owner_we    = 1'b1;
        owner_waddr = AW'(count);
        owner_wdata = AW'(free_head);
      end
      OP_SET_WR: begin
        entry_we    = 1'b1;
        entry_waddr = AW'(p_q);
        entry_wdata = attr_q;
      end
      OP_SHIFT: begin
        // move the entry read last cycle down one slot and relink its owner
        link_we    = mv_valid;
        link_waddr = owner_q;
        link_wdata = LINK_W'(mv_dst);
        owner_we   = mv_valid;
        entry_we   = mv_valid;
      end
      OP_FREE_FIN: begin
        link_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_ren) begin
      link_q     <= link_mem[link_raddr];
      link_fresh <= CW'(link_raddr) >= hw;
      link_rstv  <= (link_succ == MAXA) ? END_MARK : LINK_W'(link_succ);
    end
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= owner_wdata;
    end
    if (owner_ren) begin
      owner_q <= owner_mem[owner_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_ren) begin
      entry_q <= entry_mem[entry_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      count     <= '0;
      hw        <= '0;
      mv_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result only loads once the previous one has been taken
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_ALLOC_WR: begin
          free_head <= link_val;
          count     <= count + CW'(1);
          if (CW'(free_head) == hw) begin
            hw <= hw + CW'(1);
          end
        end
        OP_SHIFT_INIT: mv_valid <= 1'b0;
        OP_SHIFT:      mv_valid <= shift_rd;
        OP_FREE_FIN: begin
          count     <= count - CW'(1);
          free_head <= LINK_W'(h_q);
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        req_q     <= req_t'(req_type);
        h_q       <= handle;
        pos_q     <= position;
        attr_q    <= {priority_req, attr_two, attr_one, attr_zero};
        wk_status <= ST_OK;
        wk_handle <= '0;
        wk_entry  <= '0;
      end
      OP_SET_FULL:  wk_status <= ST_FULL;
      OP_SET_RANGE: wk_status <= ST_RANGE;
      OP_ALLOC_WR:  wk_handle <= 7'(free_head);
      OP_OWNER_RD:  p_q <= link_val;
      OP_SHIFT_INIT: rd_ptr <= CW'(p_q) + CW'(1);
      OP_SHIFT: begin
        if (shift_rd) begin
          mv_pos <= AW'(rd_ptr);
          rd_ptr <= rd_ptr + CW'(1);
        end
      end
      OP_READ_WR: begin
        wk_handle <= 7'(owner_q);
        wk_entry  <= entry_q;
      end
      OP_EMIT: begin
        status          <= wk_status;
        handle_out      <= wk_handle;
        entry_attr_zero <= wk_entry[15:0];
        entry_attr_one  <= wk_entry[31:16];
        entry_attr_two  <= wk_entry[47:32];
        entry_priority  <= wk_entry[63:48];
        live_count      <= 8'(count);
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    stat.req        = req_q;
    stat.full       = (9'(count) >= MAX9) || (9'(free_head) >= MAX9);
    stat.h_ok       = 9'(h_q) < MAX9;
    stat.pos_ok     = 9'(pos_q) < 9'(count);
    stat.live       = (9'(p_q) < 9'(count)) && (owner_q == AW'(h_q));
    stat.shift_done = !mv_valid && (rd_ptr >= count);
    stat.out_free   = !out_valid || !out_stall;
  end

  // live entries never outnumber the table or the handles ever handed out
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (9'(count) <= MAX9) && (count <= hw))
    else $error("live count out of bounds");

  // a move never targets a slot below position zero
  a_move_dst: assert property (@(posedge clk) disable iff (rst)
    (op == OP_SHIFT) && mv_valid |-> mv_pos != '0)
    else $error("shift move from position zero");

  // allocation commits only with a handle on the free list
  a_alloc_head: assert property (@(posedge clk) disable iff (rst)
    (op == OP_ALLOC_WR) |-> (9'(free_head) < MAX9) && (9'(count) < MAX9))
    else $error("allocate committed on a full table");

endmodule

`default_nettype wire

// ===== hdl/ohst_ctrl.sv =====
// controller state machine sequencing each request through the datapath
`default_nettype none

module ohst_ctrl
  import ohst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_op_t        op
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.req) inside
          REQ_ALLOC:         state_next = stat.full ? S_EMIT : S_ALLOC_WR;
          REQ_FREE, REQ_SET: state_next = stat.h_ok ? S_OWNER_RD : S_EMIT;
          REQ_READ:          state_next = stat.pos_ok ? S_READ_WR : S_EMIT;
          default:           state_next = S_EMIT;
        endcase
      end
      S_ALLOC_WR: state_next = S_EMIT;
      S_OWNER_RD: state_next = S_CHECK;
      S_CHECK: begin
        if (stat.live && (stat.req == REQ_FREE)) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_FREE_FIN;
        end
      end
      S_FREE_FIN: state_next = S_EMIT;
      S_READ_WR:  state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op       = OP_NONE;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_CAPTURE;
        end
      end
      S_DISPATCH: begin
        unique case (stat.req) inside
          REQ_ALLOC:         op = stat.full ? OP_SET_FULL : OP_ALLOC_RD;
          REQ_FREE, REQ_SET: op = stat.h_ok ? OP_LINK_RD : OP_NONE;
          REQ_READ:          op = stat.pos_ok ? OP_READ_RD : OP_SET_RANGE;
          default:           op = OP_NONE;
        endcase
      end
      S_ALLOC_WR: op = OP_ALLOC_WR;
      S_OWNER_RD: op = OP_OWNER_RD;
      S_CHECK: begin
        if (stat.live && (stat.req == REQ_SET)) begin
          op = OP_SET_WR;
        end else if (stat.live && (stat.req == REQ_FREE)) begin
          op = OP_SHIFT_INIT;
        end
      end
      S_SHIFT:    op = OP_SHIFT;
      S_FREE_FIN: op = OP_FREE_FIN;
      S_READ_WR:  op = OP_READ_WR;
      S_EMIT: begin
        if (stat.out_free) begin
          op = OP_EMIT;
        end
      end
      default: op = OP_NONE;
    endcase
  end

  // the compaction loop leaves only through the free finish step
  a_shift_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |=> state == S_SHIFT || state == S_FREE_FIN)
    else $error("shift loop left early");

  // a free or set only reaches the live check after an owner lookup
  a_check_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_OWNER_RD)
    else $error("live check without owner lookup");

  // a transaction is captured only on an accepting edge
  a_capture_open: assert property (@(posedge clk) disable iff (rst)
    op == OP_CAPTURE |-> in_valid && !in_stall)
    else $error("capture without an accepted transaction");

endmodule

`default_nettype wire

// ===== hdl/ordered_handle_slot_table.sv =====
// top level of the ordered handle slot table
`default_nettype none

// Dense, ordered table of 64-bit entries reached through stable handles.
// A request transaction is taken on in_valid with in_stall low, one at a
// time, and always answers with exactly one result transaction. Allocate
// pops the head of the free list, binds the handle to the end of the table
// and returns it (status full when no handle or slot is left). Free removes
// a live handle's entry and compacts the table: every later entry moves down
// one position and its owner's link is rewritten, one entry per clock. Set
// writes the four words of a live handle's entry; free and set of a handle
// that is not live are ignored with status ok. Read returns the entry and
// owning handle at a position, or status range past the live count. Entry
// layout is attr_zero, attr_one, attr_two, priority from the low word up.
// Each transaction is captured, then dispatched; allocate then writes, read
// fetches and writes back its entry, and set and free look up the owner and
// check that the handle is live. A free of a live handle then compacts the
// table and ends with a finish step, since the compaction streams one entry a
// cycle through the single read and write port of each memory and drains the
// last move before that step. The result sits in an output register,
// so a new transaction is taken while the previous result still waits; the
// next result waits in the emit step until that one has been taken.
// No clearing pass is needed after reset: the free-list links keep a
// high-water mark, and handles at or above it read as their reset chain value.

module ordered_handle_slot_table
  import ohst_pkg::*;
#(
  parameter int MAX_ENTRIES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  handle,
  input  wire logic [6:0]  position,
  input  wire logic [15:0] attr_zero,
  input  wire logic [15:0] attr_one,
  input  wire logic [15:0] attr_two,
  input  wire logic [15:0] priority_req,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [6:0]       handle_out,
  output logic [15:0]      entry_attr_zero,
  output logic [15:0]      entry_attr_one,
  output logic [15:0]      entry_attr_two,
  output logic [15:0]      entry_priority,
  output logic [7:0]       live_count
);

  // command and status between sequencer and datapath
  dp_op_t   op;
  dp_stat_t stat;

  // sequencer: steps each transaction through lookup, check, compaction
  ohst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // datapath: memories, free list, counters and the result register
  ohst_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .stat            (stat),
    .req_type        (req_type),
    .handle          (handle),
    .position        (position),
    .attr_zero       (attr_zero),
    .attr_one        (attr_one),
    .attr_two        (attr_two),
    .priority_req    (priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .handle_out      (handle_out),
    .entry_attr_zero (entry_attr_zero),
    .entry_attr_one  (entry_attr_one),
    .entry_attr_two  (entry_attr_two),
    .entry_priority  (entry_priority),
    .live_count      (live_count)
  );

endmodule

`default_nettype wire

// ===== bench/slot_table_check_pkg.sv =====
// request and answer types and the scoreboard class for the slot table bench
`timescale 1ns / 100ps

package slot_table_check_pkg;
  import ohst_pkg::*;

  localparam int TABLE_SIZE = 128;

  typedef struct packed {
    req_t        req;
    logic [6:0]  handle;
    logic [6:0]  position;
    logic [15:0] attr_zero;
    logic [15:0] attr_one;
    logic [15:0] attr_two;
    logic [15:0] prio_word;
  } table_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  handle;
    logic [15:0] attr_zero;
    logic [15:0] attr_one;
    logic [15:0] attr_two;
    logic [15:0] prio_word;
    logic [7:0]  count;
  } table_answer_t;

  class slot_table_scoreboard;
    logic [63:0]    entry_words[TABLE_SIZE];
    bit             entry_known[TABLE_SIZE];
    logic [7:0]     link_word[TABLE_SIZE];
    logic [6:0]     position_owner[TABLE_SIZE];
    logic [7:0]     free_head;
    int unsigned    live_entries;
    table_answer_t  answers_due[$];
    int unsigned    mismatches;

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        entry_words[i] = '0;
        entry_known[i] = 1'b0;
        position_owner[i] = '0;
        link_word[i] = (i == TABLE_SIZE - 1) ? END_MARK : 8'(i + 1);
      end
      free_head = '0;
      live_entries = 0;
      mismatches = 0;
    endfunction

    function bit handle_is_live(logic [6:0] h);
      logic [7:0] p;
      p = link_word[h];
      return (p < live_entries) && (position_owner[p[6:0]] == h);
    endfunction

    function int unsigned results_pending();
      return answers_due.size();
    endfunction

    // applies one accepted request, queues its answer; 0 when it was ignored
    function bit note_request(table_request_t r);
      table_answer_t due;
      bit            effective;
      logic [6:0]    granted;
      int unsigned   slot;
      due = '0;
      effective = 1'b1;
      case (r.req)
        REQ_ALLOC: begin
          if (live_entries >= TABLE_SIZE || free_head >= TABLE_SIZE) begin
            due.status = ST_FULL;
          end else begin
            granted = free_head[6:0];
            free_head = link_word[granted];
            link_word[granted] = 8'(live_entries);
            position_owner[live_entries] = granted;
            live_entries++;
            due.handle = granted;
          end
        end
        REQ_FREE: begin
          if (handle_is_live(r.handle)) begin
            for (slot = link_word[r.handle] + 1; slot < live_entries; slot++) begin
              link_word[position_owner[slot]] = 8'(slot - 1);
              entry_words[slot - 1] = entry_words[slot];
              entry_known[slot - 1] = entry_known[slot];
              position_owner[slot - 1] = position_owner[slot];
            end
            live_entries--;
            link_word[r.handle] = free_head;
            free_head = {1'b0, r.handle};
          end else begin
            effective = 1'b0;
          end
        end
        REQ_SET: begin
          if (handle_is_live(r.handle)) begin
            entry_words[link_word[r.handle]] = {r.prio_word, r.attr_two, r.attr_one, r.attr_zero};
            entry_known[link_word[r.handle]] = 1'b1;
          end else begin
            effective = 1'b0;
          end
        end
        default: begin
          if (r.position >= live_entries) begin
            due.status = ST_RANGE;
          end else begin
            due.handle = position_owner[r.position];
            {due.prio_word, due.attr_two, due.attr_one, due.attr_zero} = entry_words[r.position];
          end
        end
      endcase
      due.count = 8'(live_entries);
      answers_due.push_back(due);
      return effective;
    endfunction

    task report(string what);
      if (mismatches < 200) $display("[%0t] error: %s", $time, what);
      mismatches++;
    endtask

    task check_field(string name, logic [15:0] seen, logic [15:0] due);
      if (seen !== due) report($sformatf("%s is %0h, expected %0h", name, seen, due));
    endtask

    task check_result(table_answer_t seen);
      table_answer_t due;
      if (answers_due.size() == 0) begin
        report("result transaction with no request outstanding");
      end else begin
        due = answers_due.pop_front();
        check_field("status", 16'(seen.status), 16'(due.status));
        check_field("handle_out", 16'(seen.handle), 16'(due.handle));
        check_field("entry_attr_zero", seen.attr_zero, due.attr_zero);
        check_field("entry_attr_one", seen.attr_one, due.attr_one);
        check_field("entry_attr_two", seen.attr_two, due.attr_two);
        check_field("entry_priority", seen.prio_word, due.prio_word);
        check_field("live_count", 16'(seen.count), 16'(due.count));
      end
    endtask
  endclass

endpackage

// ===== bench/ordered_handle_slot_table_test.sv =====
// top level bench for the ordered handle slot table: stimulus, result side, watchdog
`timescale 1ns / 100ps

module ordered_handle_slot_table_test;
  import ohst_pkg::*;
  import slot_table_check_pkg::*;

  localparam int TOTAL_ITEMS    = 1550;
  // worst free compacts 127 entries at one per cycle
  localparam int TAIL_CYCLES    = 200;
  // covers the long receiver hold plus the slowest free behind it
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [6:0]  handle;
  logic [6:0]  position;
  logic [15:0] attr_zero;
  logic [15:0] attr_one;
  logic [15:0] attr_two;
  logic [15:0] priority_req;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [6:0]  handle_out;
  logic [15:0] entry_attr_zero;
  logic [15:0] entry_attr_one;
  logic [15:0] entry_attr_two;
  logic [15:0] entry_priority;
  logic [7:0]  live_count;

  slot_table_check_pkg::slot_table_scoreboard table_check;
  int unsigned          effective_items = 0;
  int unsigned          burst_left = 0;
  bit                   sender_gaps_on = 1'b1;
  // long receiver holds asked for by the sender, served by the result side
  int unsigned          holds_asked = 0;
  int unsigned          idle_cycles = 0;

  ordered_handle_slot_table #(
    .MAX_ENTRIES (TABLE_SIZE)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .handle          (handle),
    .position        (position),
    .attr_zero       (attr_zero),
    .attr_one        (attr_one),
    .attr_two        (attr_two),
    .priority_req    (priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .handle_out      (handle_out),
    .entry_attr_zero (entry_attr_zero),
    .entry_attr_one  (entry_attr_one),
    .entry_attr_two  (entry_attr_two),
    .entry_priority  (entry_priority),
    .live_count      (live_count)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic table_request_t make_request(req_t req, logic [6:0] h, logic [6:0] pos,
                                                  logic [15:0] a0, logic [15:0] a1,
                                                  logic [15:0] a2, logic [15:0] pr);
    table_request_t r;
    r.req = req;
    r.handle = h;
    r.position = pos;
    r.attr_zero = a0;
    r.attr_one = a1;
    r.attr_two = a2;
    r.prio_word = pr;
    return r;
  endfunction

  // picks the next request from the live table; heading_up favors allocation
  function automatic table_request_t next_random_request(bit heading_up);
    table_request_t r;
    int unsigned    roll;
    int unsigned    count;
    int unsigned    start;
    int unsigned    slot;
    int unsigned    pos;
    bit             found;
    r = make_request(req_t'($urandom_range(0, 3)), 7'($urandom), 7'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    count = table_check.live_entries;
    // about one in ten stays fully random: stray handles, ignored frees and sets
    if ($urandom_range(0, 99) >= 10) begin
      roll = $urandom_range(0, 99);
      if (heading_up) begin
        if (roll < 50) r.req = REQ_ALLOC;
        else if (roll < 75) r.req = REQ_SET;
        else if (roll < 90) r.req = REQ_READ;
        else r.req = REQ_FREE;
      end else begin
        if (roll < 15) r.req = REQ_ALLOC;
        else if (roll < 30) r.req = REQ_SET;
        else if (roll < 50) r.req = REQ_READ;
        else r.req = REQ_FREE;
      end
      if ((r.req == REQ_FREE || r.req == REQ_SET) && count > 0) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) pos = 0;
        else if (roll == 1) pos = count - 1;
        else pos = $urandom_range(0, count - 1);
        // sets mostly go to entries that still hold no data
        if (r.req == REQ_SET && $urandom_range(0, 9) < 6) begin
          start = pos;
          found = 1'b0;
          for (int unsigned k = 0; k < count && !found; k++) begin
            slot = (start + k) % count;
            if (!table_check.entry_known[slot]) begin
              pos = slot;
              found = 1'b1;
            end
          end
        end
        r.handle = table_check.position_owner[pos];
      end
      if (r.req == REQ_READ && count > 0 && $urandom_range(0, 4) != 0)
        r.position = 7'($urandom_range(0, count - 1));
    end
    // a read inside the table must land on an entry that holds written data
    if (r.req == REQ_READ && r.position < count && !table_check.entry_known[r.position]) begin
      start = r.position;
      found = 1'b0;
      for (int unsigned k = 0; k < count && !found; k++) begin
        slot = (start + k) % count;
        if (table_check.entry_known[slot]) begin
          r.position = 7'(slot);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (count < TABLE_SIZE) r.position = 7'($urandom_range(count, TABLE_SIZE - 1));
        else r.req = REQ_ALLOC;
      end
    end
    return r;
  endfunction

  // offers one request transaction, waits for it to be taken, then maybe idles
  task automatic send_request(input table_request_t r);
    int unsigned gap;
    int unsigned roll;
    in_valid     <= 1'b1;
    req_type     <= r.req;
    handle       <= r.handle;
    position     <= r.position;
    attr_zero    <= r.attr_zero;
    attr_one     <= r.attr_one;
    attr_two     <= r.attr_two;
    priority_req <= r.prio_word;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (table_check.note_request(r)) effective_items++;
    gap = 0;
    if (sender_gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) burst_left = $urandom_range(20, 60);
        else if (roll < 55) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      // payload is don't-care while valid is low, so scramble it
      in_valid     <= 1'b0;
      req_type     <= 2'($urandom);
      handle       <= 7'($urandom);
      position     <= 7'($urandom);
      attr_zero    <= 16'($urandom);
      attr_one     <= 16'($urandom);
      attr_two     <= 16'($urandom);
      priority_req <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // lowers valid and waits until every outstanding result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_check.results_pending() != 0);
  endtask

  initial begin : stimulus
    int unsigned sends;
    int unsigned turn_count;
    bit          heading_up;
    table_check = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    req_type     <= REQ_ALLOC;
    handle       <= '0;
    position     <= '0;
    attr_zero    <= '0;
    attr_one     <= '0;
    attr_two     <= '0;
    priority_req <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, ignored requests, compaction from middle, end and front
    send_request(make_request(REQ_READ, 7'd0, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_FREE, 7'd0, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_SET, 7'd5, 7'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    repeat (3)
      send_request(make_request(REQ_ALLOC, 7'h7f, 7'h7f, 16'hffff, 16'h0, 16'hffff, 16'h0));
    send_request(make_request(REQ_SET, table_check.position_owner[0], 7'h7f,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(REQ_SET, table_check.position_owner[1], 7'h0,
                              16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_SET, table_check.position_owner[2], 7'h55,
                              16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    for (int p = 0; p < 3; p++)
      send_request(make_request(REQ_READ, 7'h0, 7'(p), 16'h0, 16'h0, 16'h0, 16'h0));
    // one past the end and the top position, both out of range
    send_request(make_request(REQ_READ, 7'h0, 7'd3, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_READ, 7'h0, 7'h7f, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_FREE, table_check.position_owner[1], 7'h0,
                              16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_READ, 7'h0, 7'd1, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_FREE, table_check.position_owner[1], 7'h0,
                              16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_FREE, table_check.position_owner[0], 7'h0,
                              16'h0, 16'h0, 16'h0, 16'h0));
    // freed handles come back from the free list
    send_request(make_request(REQ_ALLOC, 7'h0, 7'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_SET, table_check.position_owner[0], 7'h0,
                              16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
    send_request(make_request(REQ_READ, 7'h0, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_FREE, 7'h7f, 7'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_SET, 7'h7f, 7'h0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_request(REQ_ALLOC, 7'h0, 7'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(REQ_SET, table_check.position_owner[1], 7'h0,
                              16'h8001, 16'h4002, 16'h2004, 16'h1008));
    wait_for_drain();

    // random: sweep the table up to full and back down to empty, repeatedly
    sends = 0;
    turn_count = 0;
    heading_up = 1'b1;
    while (effective_items < TOTAL_ITEMS) begin
      if (sends == 400 || sends == 1100) begin
        // receiver holds off while the sender keeps pushing, so the block backs up
        holds_asked++;
        sender_gaps_on = 1'b0;
        repeat (16) send_request(next_random_request(heading_up));
        sender_gaps_on = 1'b1;
      end
      if (sends == 750) wait_for_drain();
      send_request(next_random_request(heading_up));
      sends++;
      if (heading_up && table_check.live_entries == TABLE_SIZE) turn_count++;
      else if (!heading_up && table_check.live_entries == 0) turn_count++;
      if (turn_count > 6) begin
        heading_up = !heading_up;
        turn_count = 0;
      end
    end

    wait_for_drain();
    // catch stray results after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (table_check.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side: checks each accepted result transaction and drives out_stall
  initial begin : result_side
    table_answer_t seen;
    int unsigned   stall_left;
    int unsigned   quiet_left;
    int unsigned   roll;
    int unsigned   holds_done;
    stall_left = 0;
    quiet_left = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen.status    = status;
        seen.handle    = handle_out;
        seen.attr_zero = entry_attr_zero;
        seen.attr_one  = entry_attr_one;
        seen.attr_two  = entry_attr_two;
        seen.prio_word = entry_priority;
        seen.count     = live_count;
        table_check.check_result(seen);
      end
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        stall_left = HOLD_CYCLES;
        quiet_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet_left > 0) begin
        // stretch with no stalls at all
        quiet_left--;
        out_stall <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          quiet_left = $urandom_range(50, 200);
          out_stall <= 1'b0;
        end else if (roll < 60) begin
          out_stall <= 1'b0;
        end else if (roll < 96) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(10, 50);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side means a hang
  always @(posedge clk) begin
    if (rst === 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== ordered_handle_slot_table.f =====
hdl/ohst_pkg.sv
hdl/ohst_datapath.sv
hdl/ohst_ctrl.sv
hdl/ordered_handle_slot_table.sv
bench/slot_table_check_pkg.sv
bench/ordered_handle_slot_table_test.sv
